// ----- hdl/ebb_pkg.sv -----
// Shared types, constants and reciprocal table for the edge-replicated box blur.
package ebb_pkg;

  localparam int RADIUS_MAX  = 15;
  localparam int LINE_MAX    = 4096;
  localparam int HIST_DEPTH  = 2 * RADIUS_MAX + 1;
  localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
  localparam int CH_W        = 8;
  localparam int RAD_W       = 4;
  localparam int LEN_W       = 13;
  localparam int POS_W       = 12;
  localparam int FAC_W       = RAD_W + 1;
  localparam int SUM_W       = $clog2(HIST_DEPTH * 255 + 1);
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = RECIP_W + SUM_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd1;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 13'd1920;

  // ceil(2^18 / (2r+1)); exact floor division for sums below 2^13
  localparam logic [RECIP_W-1:0] RECIP [RADIUS_MAX+1] = '{
    19'd262144, 19'd87382, 19'd52429, 19'd37450,
    19'd29128,  19'd23832, 19'd20165, 19'd17477,
    19'd15421,  19'd13798, 19'd12484, 19'd11398,
    19'd10486,  19'd9710,  19'd9040,  19'd8457
  };

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } ebb_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            line_end;
    logic            run_last;
  } ebb_out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- hdl/ebb_cell.sv -----
// One history cell: holds a pixel, shifts from its neighbor or loads the line's first pixel.
module ebb_cell (
  input  logic             clk,
  input  ebb_pkg::cell_ctl_t ctl,
  input  ebb_pkg::pix_t    load_pix,
  input  ebb_pkg::pix_t    prev_pix,
  output ebb_pkg::pix_t    pix
);
  import ebb_pkg::*;

  pix_t pix_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pix_r <= load_pix;
    end else if (ctl.shift) begin
      pix_r <= prev_pix;
    end
  end

  assign pix = pix_r;

endmodule

// ----- hdl/ebb_scale.sv -----
// Floor division of a channel sum by 2r+1 through a reciprocal multiply.
module ebb_scale (
  input  logic [ebb_pkg::SUM_W-1:0] sum,
  input  logic [ebb_pkg::RAD_W-1:0] rad,
  output logic [ebb_pkg::CH_W-1:0]  quot
);
  import ebb_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(sum) * PROD_W'(RECIP[rad]);
  assign quot = prod[RECIP_SHIFT +: CH_W];

endmodule

// ----- hdl/edge_replicated_box_blur_line.sv -----
// Top level: edge-replicated horizontal box blur of RGB lines.
//
//  channel | ports                       | moves
//  --------+-----------------------------+------------------------------------
//  input   | in_valid, in_stall, in_data | one pixel per request
//  output  | out_valid, out_stall, out_data | one blurred pixel per request
//  config  | cfg_we, cfg_index, cfg_data | radius / line_length writes
//
// One pixel is taken per cycle unless in_stall is high; the last pixel of a line starts
// r tail steps (r = effective radius) in which the input stalls while the row of cells
// replays the last pixel. Each result passes the m stage and the output register.
// The 31 history cells, running sums and payload stages have no reset; synchronous reset
// clears position, tail count and valids and sets the config and per-line registers to
// radius 1, length 1920. out_stall holds the pipeline and backs up into in_stall.
module edge_replicated_box_blur_line (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ebb_pkg::ebb_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ebb_pkg::ebb_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [ebb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ebb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ebb_pkg::*;

  logic [RAD_W-1:0] cfg_radius_r;
  logic [LEN_W-1:0] cfg_len_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] cur_len_r;
  logic [RAD_W-1:0] cur_rad_r;
  logic [RAD_W-1:0] tail_r, tail_nxt;
  sums_t            sum_r, sum_nxt;

  logic             m_valid_r;
  sums_t            m_sum_r;
  logic [RAD_W-1:0] m_rad_r;
  logic             m_line_end_r, m_run_last_r;

  logic             out_valid_r;
  ebb_out_t         out_data_r;

  logic out_free, m_free, tail_busy, in_take, tail_step, front_step;
  logic line_start, is_last, emit, emit_line_end, emit_run_last;
  logic [LEN_W-1:0] len_clamp, len_eff;
  logic [POS_W-1:0] half_len;
  logic [RAD_W-1:0] rad_cap, rad_new, rad_eff;
  logic [FAC_W-1:0] fac;
  pix_t             front_pix, leave_pix;
  pix_t             cell_q [HIST_DEPTH];
  cell_ctl_t        cell_ctl;
  logic [CH_W-1:0]  q_red, q_green, q_blue;

  // handshake
  assign out_free   = !out_valid_r || !out_stall;
  assign m_free     = !m_valid_r || out_free;
  assign tail_busy  = (tail_r != '0);
  assign in_stall   = tail_busy || !m_free;
  assign in_take    = in_valid && !in_stall;
  assign tail_step  = tail_busy && m_free;
  assign front_step = in_take || tail_step;
  assign line_start = (pos_r == '0) && !tail_busy;

  // per-line parameters
  always_comb begin
    if (cfg_len_r == '0) begin
      len_clamp = LEN_W'(1);
    end else if (cfg_len_r > LEN_W'(LINE_MAX)) begin
      len_clamp = LEN_W'(LINE_MAX);
    end else begin
      len_clamp = cfg_len_r;
    end
    half_len = POS_W'((len_clamp - LEN_W'(1)) >> 1);
    rad_cap  = (cfg_radius_r > RAD_W'(RADIUS_MAX)) ? RAD_W'(RADIUS_MAX) : cfg_radius_r;
    rad_new  = (POS_W'(rad_cap) > half_len) ? half_len[RAD_W-1:0] : rad_cap;
  end

  assign len_eff = line_start ? len_clamp : cur_len_r;
  assign rad_eff = line_start ? rad_new : cur_rad_r;
  assign fac     = {rad_eff, 1'b1};
  assign is_last = (LEN_W'(pos_r) + LEN_W'(1)) >= len_eff;

  assign front_pix = in_take ? pix_t'(in_data) : cell_q[0];
  assign leave_pix = cell_q[HIST_IDX_W'({rad_eff, 1'b0})];

  // running window sums
  always_comb begin
    if (line_start) begin
      sum_nxt.red   = SUM_W'(SUM_W'(fac) * SUM_W'(front_pix.red));
      sum_nxt.green = SUM_W'(SUM_W'(fac) * SUM_W'(front_pix.green));
      sum_nxt.blue  = SUM_W'(SUM_W'(fac) * SUM_W'(front_pix.blue));
    end else begin
      sum_nxt.red   = sum_r.red + SUM_W'(front_pix.red) - SUM_W'(leave_pix.red);
      sum_nxt.green = sum_r.green + SUM_W'(front_pix.green) - SUM_W'(leave_pix.green);
      sum_nxt.blue  = sum_r.blue + SUM_W'(front_pix.blue) - SUM_W'(leave_pix.blue);
    end
  end

  always_comb begin
    if (in_take) begin
      emit          = (pos_r >= POS_W'(rad_eff));
      emit_line_end = is_last && (rad_eff == '0);
      emit_run_last = !is_last || (rad_eff == '0);
    end else begin
      emit          = tail_step;
      emit_line_end = (tail_r == RAD_W'(1));
      emit_run_last = (tail_r == RAD_W'(1));
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    tail_nxt = tail_r;
    if (in_take) begin
      pos_nxt = is_last ? '0 : pos_r + POS_W'(1);
      if (is_last) begin
        tail_nxt = rad_eff;
      end
    end else if (tail_step) begin
      tail_nxt = tail_r - RAD_W'(1);
    end
  end

  // row of history cells
  assign cell_ctl.load  = in_take && line_start;
  assign cell_ctl.shift = front_step && !cell_ctl.load;

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    ebb_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .load_pix (front_pix),
      .prev_pix ((i == 0) ? front_pix : cell_q[(i == 0) ? 0 : i - 1]),
      .pix      (cell_q[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r <= RADIUS_RESET;
      cfg_len_r    <= LENGTH_RESET;
      pos_r        <= '0;
      tail_r       <= '0;
      cur_len_r    <= LENGTH_RESET;
      cur_rad_r    <= RADIUS_RESET;
      m_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIUS:      cfg_radius_r <= cfg_data[RAD_W-1:0];
          REG_LINE_LENGTH: cfg_len_r    <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      pos_r  <= pos_nxt;
      tail_r <= tail_nxt;
      if (in_take && line_start) begin
        cur_len_r <= len_clamp;
        cur_rad_r <= rad_new;
      end
      if (m_free) begin
        m_valid_r <= front_step && emit;
      end
      if (out_free) begin
        out_valid_r <= m_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (front_step) begin
      sum_r <= sum_nxt;
    end
    if (m_free) begin
      m_sum_r      <= sum_nxt;
      m_rad_r      <= rad_eff;
      m_line_end_r <= emit_line_end;
      m_run_last_r <= emit_run_last;
    end
    if (out_free) begin
      out_data_r.out_red   <= q_red;
      out_data_r.out_green <= q_green;
      out_data_r.out_blue  <= q_blue;
      out_data_r.line_end  <= m_line_end_r;
      out_data_r.run_last  <= m_run_last_r;
    end
  end

  ebb_scale u_scale_red   (.sum(m_sum_r.red),   .rad(m_rad_r), .quot(q_red));
  ebb_scale u_scale_green (.sum(m_sum_r.green), .rad(m_rad_r), .quot(q_green));
  ebb_scale u_scale_blue  (.sum(m_sum_r.blue),  .rad(m_rad_r), .quot(q_blue));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
